// ===== src/glyph_cache_use_count_replacement_macros.svh =====
// ----------------------------------------------------------------------------
// Glyph cache assertion macros
// Clocked property helpers for the glyph cache, disabled in synthesis.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CACHE_USE_COUNT_REPLACEMENT_MACROS_SVH
`define GLYPH_CACHE_USE_COUNT_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on aclk, idle during reset
`define GCR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("glyph cache check failed");
// next-cycle implication on aclk, idle during reset
`define GCR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("glyph cache check failed");
`else
`define GCR_ASSERT_IMP(name, ante, cons)
`define GCR_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== src/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph cache package
// Shared widths, result codes, register indexes and the store write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    localparam int CODE_W     = 8;
    localparam int CNT_W      = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int SLOTS_CFG_W = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int M_DATA_W   = 24;
    localparam int M_USER_W   = 2;

    typedef enum logic [1:0] {
        OUT_HIT      = 2'd0,
        OUT_FILL     = 2'd1,
        OUT_REPLACE  = 2'd2,
        OUT_NO_GLYPH = 2'd3
    } outcome_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_LIMIT  = 2'd1;

    typedef struct packed {
        logic              en;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  count;
    } wr_data_t;

endpackage

`default_nettype wire

// ===== src/gcr_store.sv =====
// ----------------------------------------------------------------------------
// Glyph cache slot store
// Code and count memory, one write and one registered read per cycle;
// per-slot valid bits make unwritten slots read as free.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_store #(
    parameter int NUM_SLOTS = 16,
    parameter int AW        = 4
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        rd_en,
    input  wire  [AW-1:0]              rd_addr,
    output logic [gcr_pkg::CODE_W-1:0] rd_code,
    output logic [gcr_pkg::CNT_W-1:0]  rd_count,
    input  wire  [AW-1:0]              wr_addr,
    input  wire  gcr_pkg::wr_data_t    wr
);

    logic [gcr_pkg::CODE_W-1:0] mem_code_reg  [NUM_SLOTS];
    logic [gcr_pkg::CNT_W-1:0]  mem_count_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]       valid_reg;
    logic [gcr_pkg::CODE_W-1:0] rd_code_reg;
    logic [gcr_pkg::CNT_W-1:0]  rd_count_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_code_reg[wr_addr]  <= wr.code;
            mem_count_reg[wr_addr] <= wr.count;
        end
        if (rd_en) begin
            rd_code_reg  <= mem_code_reg[rd_addr];
            rd_count_reg <= mem_count_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // a slot never written reads as free with code zero
    assign rd_code  = rd_valid_reg ? rd_code_reg : '0;
    assign rd_count = rd_valid_reg ? rd_count_reg : '0;

endmodule

`default_nettype wire

// ===== src/gcr_alu.sv =====
// ----------------------------------------------------------------------------
// Glyph cache count unit
// Shared compare and subtract on use counts: lt = a < b, diff = b - a.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_alu (
    input  wire  [gcr_pkg::CNT_W-1:0] op_a,
    input  wire  [gcr_pkg::CNT_W-1:0] op_b,
    output logic                      lt,
    output logic [gcr_pkg::CNT_W-1:0] diff
);

    logic [gcr_pkg::CNT_W:0] sub;

    assign sub  = {1'b0, op_b} - {1'b0, op_a};
    assign lt   = (op_a != op_b) && !sub[gcr_pkg::CNT_W];
    assign diff = sub[gcr_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

// ===== src/glyph_cache_use_count_replacement.sv =====
// ----------------------------------------------------------------------------
// Glyph cache with use-count replacement
// Looks up character codes in a small slot cache, fills or evicts by count.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one lookup item, s_tdata = char code, s_tuser = font has glyph.
//   m_ channel: one result item per lookup, outcome in m_tuser, slot index,
//   evicted code and slot count in m_tdata.
//   cfg channel: register writes (slots in use, count limit), always ready;
//   write only while no lookup is in flight.
// Sequence:
//   a lookup makes one search pass over the used slots, then a write step
//   and an output step (a miss with no glyph skips the write); a replacement
//   that ages the other counts adds a second pass over the used slots before
//   the write. No new lookup is accepted until the last one has left the
//   sequencer and it is back in idle.
//   s_tready is high only while the sequencer is idle.
// Reset: every slot free, slots in use 16, count limit 255; no clearing pass.
// Stall: the result waits in the output register; the next lookup may be
//   taken and searched, and holds at its end until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_cache_use_count_replacement_macros.svh"

module glyph_cache_use_count_replacement #(
    parameter int NUM_SLOTS = 16
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [gcr_pkg::CODE_W-1:0]      s_tdata,   // [7:0] char_code
    input  wire  [0:0]                      s_tuser,   // [0] font_has_glyph
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [3:0] slot_index, [11:4] evicted_code, [19:12] slot_count, [23:20] zero
    output logic [gcr_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [gcr_pkg::M_USER_W-1:0]    m_tuser,   // [1:0] outcome
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [gcr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [gcr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int NW = (CW > gcr_pkg::SLOTS_CFG_W) ? CW : gcr_pkg::SLOTS_CFG_W;
    localparam int CNT_W = gcr_pkg::CNT_W;
    localparam int CODE_W = gcr_pkg::CODE_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_AGE   = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [gcr_pkg::SLOTS_CFG_W-1:0] slots_reg, slots_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;

    logic [CODE_W-1:0] code_reg, code_next;
    logic              glyph_reg, glyph_next;
    logic [NW-1:0]     issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [NW-1:0]     pend_idx_reg, pend_idx_next;

    logic              hit_found_reg, hit_found_next;
    logic [NW-1:0]     hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic              free_found_reg, free_found_next;
    logic [NW-1:0]     free_idx_reg, free_idx_next;
    logic [NW-1:0]     least_idx_reg, least_idx_next;
    logic [CNT_W-1:0]  least_cnt_reg, least_cnt_next;
    logic [CODE_W-1:0] least_code_reg, least_code_next;
    logic [CNT_W-1:0]  decr_reg, decr_next;

    gcr_pkg::outcome_t res_kind_reg, res_kind_next;
    logic [NW-1:0]     res_slot_reg, res_slot_next;
    logic [CODE_W-1:0] res_evict_reg, res_evict_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;

    logic              m_valid_reg, m_valid_next;
    gcr_pkg::outcome_t out_kind_reg, out_kind_next;
    logic [gcr_pkg::SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [CODE_W-1:0] out_evict_reg, out_evict_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [NW-1:0]     slots_ext;
    logic [NW-1:0]     n_active;
    logic              rd_en;
    logic [CODE_W-1:0] rd_code;
    logic [CNT_W-1:0]  rd_count;
    logic [AW-1:0]     wr_addr;
    gcr_pkg::wr_data_t wr;
    logic [CNT_W-1:0]  alu_a, alu_b, alu_diff;
    logic              alu_lt;
    logic              s_fire;
    logic              cfg_fire;

    // ------------------------------------------------------------------------
    // slot store and shared count unit
    // ------------------------------------------------------------------------
    gcr_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (issue_reg[AW-1:0]),
        .rd_code  (rd_code),
        .rd_count (rd_count),
        .wr_addr  (wr_addr),
        .wr       (wr)
    );

    gcr_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .lt   (alu_lt),
        .diff (alu_diff)
    );

    assign s_fire   = s_tvalid && s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;

    assign slots_ext = NW'(slots_reg);
    assign n_active  = (slots_reg == '0) ? NW'(1) :
                       (slots_ext > NW'(NUM_SLOTS)) ? NW'(NUM_SLOTS) : slots_ext;

    assign rd_en = (state_reg == ST_SCAN || state_reg == ST_AGE) && (issue_reg < n_active);

    // count unit operands by phase
    always_comb begin
        alu_a = decr_reg;
        alu_b = rd_count;
        if (state_reg == ST_SCAN) begin
            if (pend_reg) begin
                alu_a = rd_count;
                alu_b = least_cnt_reg;
            end else begin
                alu_a = hit_cnt_reg;
                alu_b = limit_reg;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        slots_next      = slots_reg;
        limit_next      = limit_reg;
        code_next       = code_reg;
        glyph_next      = glyph_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = issue_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        least_idx_next  = least_idx_reg;
        least_cnt_next  = least_cnt_reg;
        least_code_next = least_code_reg;
        decr_next       = decr_reg;
        res_kind_next   = res_kind_reg;
        res_slot_next   = res_slot_reg;
        res_evict_next  = res_evict_reg;
        res_cnt_next    = res_cnt_reg;
        m_valid_next    = m_valid_reg;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_evict_next  = out_evict_reg;
        out_cnt_next    = out_cnt_reg;
        wr_addr         = pend_idx_reg[AW-1:0];
        wr              = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_fire) begin
            unique case (cfg_addr)
                gcr_pkg::CFG_SLOTS_IN_USE: slots_next = cfg_data[gcr_pkg::SLOTS_CFG_W-1:0];
                gcr_pkg::CFG_COUNT_LIMIT:  limit_next = cfg_data;
                default: ;
            endcase
        end

        if (rd_en) begin
            pend_next  = 1'b1;
            issue_next = issue_reg + NW'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    code_next       = s_tdata;
                    glyph_next      = s_tuser[0];
                    issue_next      = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    least_idx_next  = '0;
                    least_cnt_next  = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (!hit_found_reg && rd_count != '0 && rd_code == code_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = pend_idx_reg;
                        hit_cnt_next   = rd_count;
                    end
                    if (!free_found_reg && rd_count == '0) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                    // strict compare keeps the lowest index on ties
                    if (pend_idx_reg == '0 || alu_lt) begin
                        least_idx_next  = pend_idx_reg;
                        least_cnt_next  = rd_count;
                        least_code_next = rd_code;
                    end
                end else if (!rd_en) begin
                    res_evict_next = '0;
                    res_cnt_next   = CNT_W'(1);
                    priority if (hit_found_reg) begin
                        res_kind_next = gcr_pkg::OUT_HIT;
                        res_slot_next = hit_idx_reg;
                        res_cnt_next  = alu_lt ? CNT_W'(hit_cnt_reg + CNT_W'(1)) : hit_cnt_reg;
                        state_next    = ST_WRITE;
                    end else if (!glyph_reg) begin
                        res_kind_next = gcr_pkg::OUT_NO_GLYPH;
                        res_slot_next = '0;
                        res_cnt_next  = '0;
                        state_next    = ST_DONE;
                    end else if (free_found_reg) begin
                        res_kind_next = gcr_pkg::OUT_FILL;
                        res_slot_next = free_idx_reg;
                        state_next    = ST_WRITE;
                    end else begin
                        res_kind_next  = gcr_pkg::OUT_REPLACE;
                        res_slot_next  = least_idx_reg;
                        res_evict_next = least_code_reg;
                        decr_next      = least_cnt_reg - CNT_W'(1);
                        if (least_cnt_reg > CNT_W'(1)) begin
                            issue_next = '0;
                            state_next = ST_AGE;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_AGE: begin
                // read-modify-write of each used count, one slot per cycle
                if (pend_reg) begin
                    wr.en    = alu_lt;
                    wr.code  = rd_code;
                    wr.count = alu_diff;
                end else if (!rd_en) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_addr    = res_slot_reg[AW-1:0];
                wr.en      = 1'b1;
                wr.code    = code_reg;
                wr.count   = res_cnt_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_slot_next  = res_slot_reg[gcr_pkg::SLOT_OUT_W-1:0];
                    out_evict_next = res_evict_reg;
                    out_cnt_next   = res_cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slots_reg   <= gcr_pkg::SLOTS_CFG_W'(16);
            limit_reg   <= CNT_W'(255);
            pend_reg    <= 1'b0;
            issue_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slots_reg   <= slots_next;
            limit_reg   <= limit_next;
            pend_reg    <= pend_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg       <= code_next;
        glyph_reg      <= glyph_next;
        pend_idx_reg   <= pend_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_cnt_reg    <= hit_cnt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        least_idx_reg  <= least_idx_next;
        least_cnt_reg  <= least_cnt_next;
        least_code_reg <= least_code_next;
        decr_reg       <= decr_next;
        res_kind_reg   <= res_kind_next;
        res_slot_reg   <= res_slot_next;
        res_evict_reg  <= res_evict_next;
        res_cnt_reg    <= res_cnt_next;
        out_kind_reg   <= out_kind_next;
        out_slot_reg   <= out_slot_next;
        out_evict_reg  <= out_evict_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tdata   = {4'b0000, out_cnt_reg, out_evict_reg, out_slot_reg};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `GCR_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `GCR_ASSERT_IMP(a_no_glyph_zero, m_tvalid && m_tuser == gcr_pkg::OUT_NO_GLYPH, m_tdata == '0)
    `GCR_ASSERT_IMP(a_alloc_count_one, m_tvalid && (m_tuser == gcr_pkg::OUT_FILL || m_tuser == gcr_pkg::OUT_REPLACE), m_tdata[19:12] == 8'd1)

endmodule

`default_nettype wire
